// ----- rtl/srmf_pkg.sv -----
// Shared constants, codes and control types of the least-squares regression block.
`default_nettype none

package srmf_pkg;

	localparam int MAX_ROWS_DEF    = 65536;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int OUT_W  = 48;
	localparam int SE_W   = 47;
	localparam int DF_W   = 16;
	localparam int RK_W   = 17;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_SING = 2'd2;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
	localparam logic [OP_W-1:0] OP_SUBC  = 3'd2;
	localparam logic [OP_W-1:0] OP_DIVF  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV2F = 3'd4;
	localparam logic [OP_W-1:0] OP_SQRT  = 3'd5;

	// Operand codes: scratch memory entries, result registers, accumulator views.
	localparam int CODE_W = 5;
	localparam logic [CODE_W-1:0] R_T0    = 5'd0;
	localparam logic [CODE_W-1:0] R_T1    = 5'd1;
	localparam logic [CODE_W-1:0] R_DXX   = 5'd2;
	localparam logic [CODE_W-1:0] R_DXY   = 5'd3;
	localparam logic [CODE_W-1:0] R_DYY   = 5'd4;
	localparam logic [CODE_W-1:0] R_E     = 5'd5;
	localparam logic [CODE_W-1:0] R_ANUM  = 5'd6;
	localparam logic [CODE_W-1:0] R_DENB  = 5'd7;
	localparam logic [CODE_W-1:0] R_DENA  = 5'd8;
	localparam logic [CODE_W-1:0] R_B     = 5'd9;
	localparam logic [CODE_W-1:0] R_A     = 5'd10;
	localparam logic [CODE_W-1:0] R_SEB   = 5'd11;
	localparam logic [CODE_W-1:0] R_SEA   = 5'd12;
	localparam logic [CODE_W-1:0] C_N     = 5'd16;
	localparam logic [CODE_W-1:0] C_NM2   = 5'd17;
	localparam logic [CODE_W-1:0] C_SX    = 5'd18;
	localparam logic [CODE_W-1:0] C_SY    = 5'd19;
	localparam logic [CODE_W-1:0] C_SXX   = 5'd20;
	localparam logic [CODE_W-1:0] C_SYY   = 5'd21;
	localparam logic [CODE_W-1:0] C_SXY   = 5'd22;

	typedef struct packed {
		logic                acc_en;
		logic                start;
		logic [OP_W-1:0]     op;
		logic [CODE_W-1:0]   src_a;
		logic [CODE_W-1:0]   src_b;
		logic [CODE_W-1:0]   dst;
		logic                load_out;
		logic [STAT_W-1:0]   status;
	} ctl_t;

	typedef struct packed {
		logic done;
		logic dxx_pos;
		logic few_rows;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/simple_regression_with_missing_filter.sv -----
// Top level of the least-squares line fit with missing-row filtering.
`default_nettype none

// Rows are taken one per clock while in_stall is low: rows flagged missing are dropped, kept
// rows update the count and the sums of x, y, xx, yy and xy through a two-stage accumulator.
// The row marked last_row starts the fit, and in_stall stays high until the result has been
// placed in the output register. The fit is a fixed program of 25 steps, four of them
// divisions and two square roots, on one shared arithmetic unit of W bits (W = 194 at the
// default parameters). A marker with fewer than three kept rows finishes without running
// the program, and a singular one after the first three steps. A finished result may wait
// in the output register while the rows of the next marker are taken.
module simple_regression_with_missing_filter #(
	parameter int MAX_ROWS    = srmf_pkg::MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = srmf_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = srmf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       trait_value,
	input  logic signed [SAMPLE_BITS-1:0]       marker_value,
	input  logic                                trait_missing,
	input  logic                                marker_missing,
	input  logic                                last_row,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [srmf_pkg::OUT_W-1:0]   intercept,
	output logic signed [srmf_pkg::OUT_W-1:0]   slope,
	output logic [srmf_pkg::SE_W-1:0]           intercept_stderr,
	output logic [srmf_pkg::SE_W-1:0]           slope_stderr,
	output logic [srmf_pkg::DF_W-1:0]           residual_df,
	output logic [srmf_pkg::RK_W-1:0]           rows_kept,
	output logic [srmf_pkg::STAT_W-1:0]         fit_status
);
	import srmf_pkg::*;

	ctl_t ctl;
	sts_t sts;

	srmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_row  (last_row),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	srmf_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.trait_value      (trait_value),
		.marker_value     (marker_value),
		.trait_missing    (trait_missing),
		.marker_missing   (marker_missing),
		.intercept        (intercept),
		.slope            (slope),
		.intercept_stderr (intercept_stderr),
		.slope_stderr     (slope_stderr),
		.residual_df      (residual_df),
		.rows_kept        (rows_kept),
		.fit_status       (fit_status)
	);

endmodule

`default_nettype wire

// ----- rtl/srmf_ctrl.sv -----
// Controller: request handshakes and the microprogram that sequences the fit.
`default_nettype none

module srmf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_row,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  srmf_pkg::sts_t sts,
	output srmf_pkg::ctl_t ctl
);
	import srmf_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CODE_W-1:0] a;
		logic [CODE_W-1:0] b;
		logic [CODE_W-1:0] dst;
	} step_t;

	localparam int NSTEP      = 25;
	localparam int PC_W       = $clog2(NSTEP);
	localparam int CHECK_STEP = 2;
	localparam int LAST_STEP  = NSTEP - 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [PC_W-1:0]   pc_q;
	logic [STAT_W-1:0] status_q;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;
	step_t             cur;

	function automatic step_t step_rom(input logic [PC_W-1:0] pc);
		step_t s;
		s = '{op: OP_MUL, a: C_N, b: C_N, dst: R_T0};
		case (pc)
			5'd0:  s = '{op: OP_MUL,   a: C_N,    b: C_SXX,  dst: R_T0};
			5'd1:  s = '{op: OP_MUL,   a: C_SX,   b: C_SX,   dst: R_T1};
			5'd2:  s = '{op: OP_SUB,   a: R_T0,   b: R_T1,   dst: R_DXX};
			5'd3:  s = '{op: OP_MUL,   a: C_N,    b: C_SXY,  dst: R_T0};
			5'd4:  s = '{op: OP_MUL,   a: C_SX,   b: C_SY,   dst: R_T1};
			5'd5:  s = '{op: OP_SUB,   a: R_T0,   b: R_T1,   dst: R_DXY};
			5'd6:  s = '{op: OP_MUL,   a: C_N,    b: C_SYY,  dst: R_T0};
			5'd7:  s = '{op: OP_MUL,   a: C_SY,   b: C_SY,   dst: R_T1};
			5'd8:  s = '{op: OP_SUB,   a: R_T0,   b: R_T1,   dst: R_DYY};
			5'd9:  s = '{op: OP_MUL,   a: R_DYY,  b: R_DXX,  dst: R_T0};
			5'd10: s = '{op: OP_MUL,   a: R_DXY,  b: R_DXY,  dst: R_T1};
			5'd11: s = '{op: OP_SUBC,  a: R_T0,   b: R_T1,   dst: R_E};
			5'd12: s = '{op: OP_MUL,   a: C_SXX,  b: C_SY,   dst: R_T0};
			5'd13: s = '{op: OP_MUL,   a: C_SX,   b: C_SXY,  dst: R_T1};
			5'd14: s = '{op: OP_SUB,   a: R_T0,   b: R_T1,   dst: R_ANUM};
			5'd15: s = '{op: OP_DIVF,  a: R_DXY,  b: R_DXX,  dst: R_B};
			5'd16: s = '{op: OP_DIVF,  a: R_ANUM, b: R_DXX,  dst: R_A};
			5'd17: s = '{op: OP_MUL,   a: R_DXX,  b: R_DXX,  dst: R_T0};
			5'd18: s = '{op: OP_MUL,   a: R_T0,   b: C_NM2,  dst: R_DENB};
			5'd19: s = '{op: OP_MUL,   a: R_DENB, b: C_N,    dst: R_DENA};
			5'd20: s = '{op: OP_DIV2F, a: R_E,    b: R_DENB, dst: R_T0};
			5'd21: s = '{op: OP_SQRT,  a: R_T0,   b: C_N,    dst: R_SEB};
			5'd22: s = '{op: OP_MUL,   a: R_E,    b: C_SXX,  dst: R_T1};
			5'd23: s = '{op: OP_DIV2F, a: R_T1,   b: R_DENA, dst: R_T0};
			5'd24: s = '{op: OP_SQRT,  a: R_T0,   b: C_N,    dst: R_SEA};
			default: s = '{op: OP_MUL, a: C_N, b: C_N, dst: R_T0};
		endcase
		return s;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cur       = step_rom(pc_q);

	always_comb begin
		ctl          = '0;
		ctl.acc_en   = accept;
		ctl.start    = (state_q == S_ISSUE);
		ctl.op       = cur.op;
		ctl.src_a    = cur.a;
		ctl.src_b    = cur.b;
		ctl.dst      = cur.dst;
		ctl.load_out = (state_q == S_DONE) && out_free;
		ctl.status   = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && last_row) state_q <= S_START;
				end
				S_START: begin
					if (sts.few_rows) begin
						status_q <= ST_FEW;
						state_q  <= S_DONE;
					end else begin
						pc_q    <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.done) begin
						if (pc_q == PC_W'(CHECK_STEP) && !sts.dxx_pos) begin
							status_q <= ST_SING;
							state_q  <= S_DONE;
						end else if (pc_q == PC_W'(LAST_STEP)) begin
							status_q <= ST_OK;
							state_q  <= S_DONE;
						end else begin
							pc_q    <= pc_q + PC_W'(1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/srmf_dp.sv -----
// Datapath: row accumulators, scratch memory and the shared multiply, divide and root unit.
`default_nettype none

module srmf_dp #(
	parameter int MAX_ROWS    = srmf_pkg::MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = srmf_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = srmf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srmf_pkg::ctl_t                      ctl,
	output srmf_pkg::sts_t                      sts,
	input  logic signed [SAMPLE_BITS-1:0]       trait_value,
	input  logic signed [SAMPLE_BITS-1:0]       marker_value,
	input  logic                                trait_missing,
	input  logic                                marker_missing,
	output logic signed [srmf_pkg::OUT_W-1:0]   intercept,
	output logic signed [srmf_pkg::OUT_W-1:0]   slope,
	output logic [srmf_pkg::SE_W-1:0]           intercept_stderr,
	output logic [srmf_pkg::SE_W-1:0]           slope_stderr,
	output logic [srmf_pkg::DF_W-1:0]           residual_df,
	output logic [srmf_pkg::RK_W-1:0]           rows_kept,
	output logic [srmf_pkg::STAT_W-1:0]         fit_status
);
	import srmf_pkg::*;

	localparam int NB        = $clog2(MAX_ROWS + 1);
	localparam int SXW       = SAMPLE_BITS + NB;
	localparam int PW        = 2 * SAMPLE_BITS;
	localparam int SQW       = 2 * SAMPLE_BITS + NB;
	// The widest value is the intercept error numerator E * sum_xx scaled by 2^(2F).
	localparam int WW_RAW    = 5 * NB + 6 * SAMPLE_BITS + 2 * FRAC_BITS + 4;
	localparam int WW        = ((WW_RAW + 1) / 2) * 2;
	localparam int CW        = $clog2(WW + 1);
	localparam int MEM_DEPTH = 9;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	localparam logic [1:0] ES_IDLE  = 2'd0;
	localparam logic [1:0] ES_FETCH = 2'd1;
	localparam logic [1:0] ES_SETUP = 2'd2;
	localparam logic [1:0] ES_RUN   = 2'd3;

	// Row accumulation.
	logic [NB-1:0]          kept_q;
	logic                   keep;
	logic                   v_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic signed [PW-1:0]   pxx_s1, pyy_s1, pxy_s1;
	logic signed [SXW-1:0]  sum_x_q, sum_y_q;
	logic signed [SQW-1:0]  sum_xx_q, sum_yy_q, sum_xy_q;

	assign keep = ctl.acc_en && !trait_missing && !marker_missing && (kept_q < NB'(MAX_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q   <= '0;
			v_s1     <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else begin
			v_s1 <= keep;
			if (ctl.load_out) begin
				kept_q   <= '0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
			end else begin
				if (keep) kept_q <= kept_q + NB'(1);
				if (v_s1) begin
					sum_x_q  <= sum_x_q + SXW'(x_s1);
					sum_y_q  <= sum_y_q + SXW'(y_s1);
					sum_xx_q <= sum_xx_q + SQW'(pxx_s1);
					sum_yy_q <= sum_yy_q + SQW'(pyy_s1);
					sum_xy_q <= sum_xy_q + SQW'(pxy_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			x_s1   <= marker_value;
			y_s1   <= trait_value;
			pxx_s1 <= marker_value * marker_value;
			pyy_s1 <= trait_value * trait_value;
			pxy_s1 <= marker_value * trait_value;
		end
	end

	// Arithmetic unit.
	logic [1:0]             es_q;
	logic [CW-1:0]          cnt_q;
	logic                   done_q;
	logic                   dxx_pos_q;
	logic [OP_W-1:0]        op_q;
	logic [CODE_W-1:0]      dst_q;
	logic [CODE_W-1:0]      src_a_q, src_b_q;
	logic signed [WW-1:0]   rd_a_q, rd_b_q;
	logic [WW-1:0]          x_q, y_q, p_q, r_q;
	logic                   neg_q;
	logic signed [WW-1:0]   res_a_q, res_b_q, res_sea_q, res_seb_q;
	logic signed [WW-1:0]   mem [0:MEM_DEPTH-1];

	logic                   is_sub;
	logic                   run_done;
	logic                   wr_en;
	logic signed [WW-1:0]   wr_val;
	logic signed [WW-1:0]   diff;
	logic [WW-1:0]          amag, bmag;
	logic [WW-1:0]          r2_div, r2_sq, trial;

	function automatic logic signed [WW-1:0] acc_src(input logic [CODE_W-1:0] c);
		logic signed [WW-1:0] v;
		v = '0;
		case (c)
			C_N:     v = WW'(kept_q);
			C_NM2:   v = WW'(kept_q) - WW'(2);
			C_SX:    v = WW'(sum_x_q);
			C_SY:    v = WW'(sum_y_q);
			C_SXX:   v = WW'(sum_xx_q);
			C_SYY:   v = WW'(sum_yy_q);
			C_SXY:   v = WW'(sum_xy_q);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign is_sub = (op_q == OP_SUB) || (op_q == OP_SUBC);
	assign diff   = rd_a_q - rd_b_q;
	assign amag   = rd_a_q[WW-1] ? WW'(-rd_a_q) : rd_a_q;
	assign bmag   = rd_b_q[WW-1] ? WW'(-rd_b_q) : rd_b_q;
	assign r2_div = {r_q[WW-2:0], x_q[WW-1]};
	assign r2_sq  = {r_q[WW-3:0], x_q[WW-1:WW-2]};
	assign trial  = {p_q[WW-3:0], 2'b01};

	always_comb begin
		run_done = 1'b0;
		if (es_q == ES_RUN) begin
			if (op_q == OP_MUL) run_done = (y_q == '0);
			else run_done = (cnt_q == '0);
		end
	end

	assign wr_en = ((es_q == ES_SETUP) && is_sub) || run_done;

	always_comb begin
		case (op_q)
			OP_SUB:   wr_val = diff;
			OP_SUBC:  wr_val = diff[WW-1] ? '0 : diff;
			OP_MUL:   wr_val = neg_q ? $signed(-p_q) : $signed(p_q);
			OP_DIVF,
			OP_DIV2F: wr_val = neg_q ? $signed(-x_q) : $signed(x_q);
			OP_SQRT:  wr_val = $signed(p_q);
			default:  wr_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q      <= ES_IDLE;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			dxx_pos_q <= 1'b0;
			op_q      <= OP_MUL;
			dst_q     <= R_T0;
		end else begin
			done_q <= wr_en;
			if (wr_en && dst_q == R_DXX) dxx_pos_q <= !wr_val[WW-1] && (wr_val != '0);
			case (es_q)
				ES_IDLE: begin
					if (ctl.start) begin
						op_q  <= ctl.op;
						dst_q <= ctl.dst;
						es_q  <= ES_FETCH;
					end
				end
				ES_FETCH: es_q <= ES_SETUP;
				ES_SETUP: begin
					if (is_sub) es_q <= ES_IDLE;
					else es_q <= ES_RUN;
					if (op_q == OP_SQRT) cnt_q <= CW'(WW / 2);
					else cnt_q <= CW'(WW);
				end
				ES_RUN: begin
					if (run_done) es_q <= ES_IDLE;
					else if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
				end
				default: es_q <= ES_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (es_q == ES_IDLE && ctl.start) begin
			src_a_q <= ctl.src_a;
			src_b_q <= ctl.src_b;
		end
		if (es_q == ES_FETCH) begin
			rd_a_q <= src_a_q[CODE_W-1] ? acc_src(src_a_q) : mem[src_a_q[MEM_AW-1:0]];
			rd_b_q <= src_b_q[CODE_W-1] ? acc_src(src_b_q) : mem[src_b_q[MEM_AW-1:0]];
		end
		if (es_q == ES_SETUP) begin
			r_q <= '0;
			p_q <= '0;
			case (op_q)
				OP_MUL: begin
					x_q   <= amag;
					y_q   <= bmag;
					neg_q <= rd_a_q[WW-1] ^ rd_b_q[WW-1];
				end
				OP_DIVF: begin
					x_q   <= amag << FRAC_BITS;
					y_q   <= rd_b_q;
					neg_q <= rd_a_q[WW-1];
				end
				OP_DIV2F: begin
					x_q   <= amag << (2 * FRAC_BITS);
					y_q   <= rd_b_q;
					neg_q <= rd_a_q[WW-1];
				end
				OP_SQRT: begin
					x_q   <= rd_a_q;
					neg_q <= 1'b0;
				end
				default: neg_q <= 1'b0;
			endcase
		end
		if (es_q == ES_RUN && !run_done) begin
			case (op_q)
				OP_MUL: begin
					if (y_q[0]) p_q <= p_q + x_q;
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				OP_DIVF,
				OP_DIV2F: begin
					// Restoring division; the dividend register fills with quotient bits.
					if (r2_div >= y_q) begin
						r_q <= r2_div - y_q;
						x_q <= {x_q[WW-2:0], 1'b1};
					end else begin
						r_q <= r2_div;
						x_q <= {x_q[WW-2:0], 1'b0};
					end
				end
				OP_SQRT: begin
					x_q <= x_q << 2;
					if (r2_sq >= trial) begin
						r_q <= r2_sq - trial;
						p_q <= {p_q[WW-2:0], 1'b1};
					end else begin
						r_q <= r2_sq;
						p_q <= {p_q[WW-2:0], 1'b0};
					end
				end
				default: x_q <= x_q;
			endcase
		end
		if (wr_en) begin
			case (dst_q)
				R_B:     res_b_q   <= wr_val;
				R_A:     res_a_q   <= wr_val;
				R_SEB:   res_seb_q <= wr_val;
				R_SEA:   res_sea_q <= wr_val;
				default: res_a_q   <= res_a_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && dst_q < CODE_W'(MEM_DEPTH)) mem[dst_q[MEM_AW-1:0]] <= wr_val;
	end

	assign sts.done     = done_q;
	assign sts.dxx_pos  = dxx_pos_q;
	assign sts.few_rows = (kept_q < NB'(3));

	// Saturation into the result formats.
	logic                     a_fits, b_fits, sea_fits, seb_fits;
	logic signed [OUT_W-1:0]  a_sat, b_sat;
	logic [SE_W-1:0]          sea_sat, seb_sat;
	logic signed [OUT_W-1:0]  intercept_q, slope_q;
	logic [SE_W-1:0]          intercept_stderr_q, slope_stderr_q;
	logic [DF_W-1:0]          residual_df_q;
	logic [RK_W-1:0]          rows_kept_q;
	logic [STAT_W-1:0]        fit_status_q;

	assign a_fits   = (res_a_q[WW-1:OUT_W-1] == '0) || (res_a_q[WW-1:OUT_W-1] == '1);
	assign b_fits   = (res_b_q[WW-1:OUT_W-1] == '0) || (res_b_q[WW-1:OUT_W-1] == '1);
	assign sea_fits = (res_sea_q[WW-1:SE_W] == '0);
	assign seb_fits = (res_seb_q[WW-1:SE_W] == '0);
	assign a_sat    = a_fits ? res_a_q[OUT_W-1:0] :
		(res_a_q[WW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});
	assign b_sat    = b_fits ? res_b_q[OUT_W-1:0] :
		(res_b_q[WW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});
	assign sea_sat  = sea_fits ? res_sea_q[SE_W-1:0] : '1;
	assign seb_sat  = seb_fits ? res_seb_q[SE_W-1:0] : '1;

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (ctl.status == ST_OK) begin
				intercept_q        <= a_sat;
				slope_q            <= b_sat;
				intercept_stderr_q <= sea_sat;
				slope_stderr_q     <= seb_sat;
			end else begin
				intercept_q        <= '0;
				slope_q            <= '0;
				intercept_stderr_q <= '0;
				slope_stderr_q     <= '0;
			end
			residual_df_q <= (kept_q >= NB'(2)) ? DF_W'(kept_q - NB'(2)) : '0;
			rows_kept_q   <= RK_W'(kept_q);
			fit_status_q  <= ctl.status;
		end
	end

	assign intercept        = intercept_q;
	assign slope            = slope_q;
	assign intercept_stderr = intercept_stderr_q;
	assign slope_stderr     = slope_stderr_q;
	assign residual_df      = residual_df_q;
	assign rows_kept        = rows_kept_q;
	assign fit_status       = fit_status_q;

endmodule

`default_nettype wire

// ----- rtl/srmf_checker.sv -----
// Port-level checks on the result channel of the regression block, with its bind.
`default_nettype none

module srmf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [srmf_pkg::OUT_W-1:0]   intercept,
	input logic signed [srmf_pkg::OUT_W-1:0]   slope,
	input logic [srmf_pkg::SE_W-1:0]           intercept_stderr,
	input logic [srmf_pkg::SE_W-1:0]           slope_stderr,
	input logic [srmf_pkg::DF_W-1:0]           residual_df,
	input logic [srmf_pkg::RK_W-1:0]           rows_kept,
	input logic [srmf_pkg::STAT_W-1:0]         fit_status
);
	import srmf_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(intercept) && $stable(slope) && $stable(fit_status))
		else $error("stalled result request changed");

	// A failed fit must not leak values left over from an earlier marker.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fit_status == ST_FEW || fit_status == ST_SING) |->
		intercept == '0 && slope == '0 && intercept_stderr == '0 && slope_stderr == '0)
		else $error("failed fit carries nonzero results");

	a_df: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rows_kept >= RK_W'(2) |-> residual_df == DF_W'(rows_kept - RK_W'(2)))
		else $error("residual degrees of freedom disagree with row count");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fit_status == ST_OK |-> rows_kept >= RK_W'(3))
		else $error("fit reported good with too few rows");

endmodule

bind simple_regression_with_missing_filter srmf_checker u_srmf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.intercept        (intercept),
	.slope            (slope),
	.intercept_stderr (intercept_stderr),
	.slope_stderr     (slope_stderr),
	.residual_df      (residual_df),
	.rows_kept        (rows_kept),
	.fit_status       (fit_status)
);

`default_nettype wire
